// ===== hdl/dsat_pkg.sv =====
// Shared types, constants and the arctangent table for the aim tracker.
// Used by every module of the block; depends on nothing.
`default_nettype none

package dsat_pkg;

  // CORDIC iteration count and the length of the arctangent table
  localparam int CORDIC_STEPS = 16;
  localparam int TABLE_LEN    = 24;
  localparam int RUN_STEPS    = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
  localparam int STEP_BITS    = $clog2(RUN_STEPS);
  localparam int TAB_IDX_BITS = $clog2(TABLE_LEN);

  // working width of the CORDIC vector: 32-bit inputs plus quarter turn and gain
  localparam int CW = 35;

  localparam int COUNT_BITS = 32;

  // input queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  localparam int PADDR_BITS = 4;

  // register reset values
  localparam logic [7:0]  REACTION_DELAY_RST  = 8'd15;
  localparam logic [14:0] MAX_YAW_STEP_RST    = 15'd1024;
  localparam logic [14:0] ALIGN_TOL_RST       = 15'd650;
  localparam logic [15:0] HOME_YAW_RST        = 16'd0;

  localparam logic [15:0] HALF_TURN    = 16'h8000;
  localparam logic [31:0] ACC_QUARTER  = 32'h4000_0000;
  localparam logic [31:0] ACC_3QUARTER = 32'hC000_0000;

  typedef enum logic [1:0] {
    REG_REACTION_DELAY = 2'd0,
    REG_MAX_YAW_STEP   = 2'd1,
    REG_ALIGN_TOL      = 2'd2,
    REG_HOME_YAW       = 2'd3
  } reg_idx_t;

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_DELAY = 3'd1;
  localparam logic [2:0] PH_TURN  = 3'd2;
  localparam logic [2:0] PH_FIRE  = 3'd3;
  localparam logic [2:0] PH_CHECK = 3'd4;

  localparam logic [31:0] ATAN_TABLE [TABLE_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  function automatic logic [31:0] atan_of(input logic [STEP_BITS-1:0] idx);
    return ATAN_TABLE[TAB_IDX_BITS'(idx)];
  endfunction

  // classified beat as it waits in the queue
  typedef struct packed {
    logic                 present;
    logic                 needs_cordic;  // present and y nonzero
    logic [15:0]          fixed_angle;   // aim when no CORDIC run is needed
    logic [31:0]          tick;
    logic signed [CW-1:0] nx;
    logic signed [CW-1:0] ny;
    logic [31:0]          acc;
  } q_item_t;

  typedef struct packed {
    logic [7:0]  reaction_delay;
    logic [14:0] max_yaw_step;
    logic [14:0] align_tolerance;
  } cfg_t;

  typedef struct packed {
    logic                 start;
    logic signed [CW-1:0] nx;
    logic signed [CW-1:0] ny;
    logic [31:0]          acc;
  } cordic_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [15:0] angle;
  } cordic_rsp_t;

endpackage

`default_nettype wire

// ===== hdl/dsat_front.sv =====
// Front end: accepts tick beats, does the quarter-turn pre-rotation and
// classifies the special angles. Depends on dsat_pkg.
`default_nettype none

module dsat_front import dsat_pkg::*; (
  input  wire logic               item_valid,
  output logic                    item_ready,
  input  wire logic               target_present,
  input  wire logic signed [31:0] target_x,
  input  wire logic signed [31:0] target_y,
  input  wire logic [31:0]        tick_stamp,
  input  wire logic               q_space,
  output logic                    q_push,
  output q_item_t                 q_wdata
);

  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  logic                 y_zero;

  assign xs     = CW'(target_x);
  assign ys     = CW'(target_y);
  assign y_zero = (target_y == 32'sd0);

  assign item_ready = q_space;
  assign q_push     = item_valid && q_space;

  always_comb begin
    q_wdata.present      = target_present;
    q_wdata.needs_cordic = target_present && !y_zero;
    q_wdata.tick         = tick_stamp;
    // on the x axis the angle is 0 or a half turn; a lost target aims at 0
    q_wdata.fixed_angle  = (target_present && target_x[31]) ? HALF_TURN : 16'd0;
    if (!target_y[31]) begin
      q_wdata.nx  = ys;
      q_wdata.ny  = -xs;
      q_wdata.acc = ACC_QUARTER;
    end else begin
      q_wdata.nx  = -ys;
      q_wdata.ny  = xs;
      q_wdata.acc = ACC_3QUARTER;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/dsat_queue.sv =====
// Short flop-based queue of classified beats between front and back.
// Depends on dsat_pkg.
`default_nettype none

module dsat_queue import dsat_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire q_item_t wdata,
  output logic         space,
  input  wire logic    pop,
  output logic         avail,
  output q_item_t      head
);

  q_item_t              slots [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QPTR_BITS:0]   fill;

  assign space = (fill != (QPTR_BITS + 1)'(QUEUE_DEPTH));
  assign avail = (fill != '0);
  assign head  = slots[rd_ptr];

  // depth is a power of two, so the pointers wrap on their own
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/dsat_cordic.sv =====
// Iterative vectoring CORDIC, one micro-rotation per cycle, giving the
// binary angle of a pre-rotated vector. Depends on dsat_pkg.
`default_nettype none

module dsat_cordic import dsat_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cordic_req_t req,
  output cordic_rsp_t      rsp
);

  logic signed [CW-1:0] vx;
  logic signed [CW-1:0] vy;
  logic [31:0]          acc;
  logic [STEP_BITS-1:0] step;
  logic                 busy;
  logic                 done;

  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;
  logic [31:0]          ang;

  assign dx  = vy >>> step;
  assign dy  = vx >>> step;
  assign ang = atan_of(step);

  assign rsp.busy  = busy;
  assign rsp.done  = done;
  assign rsp.angle = acc[31:16];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        if (step == STEP_BITS'(RUN_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step + 1'b1;
        end
      end
    end
  end

  // once y reaches zero the vector and angle are final
  always_ff @(posedge clk) begin
    if (req.start) begin
      vx  <= req.nx;
      vy  <= req.ny;
      acc <= req.acc;
    end else if (busy && (vy != '0)) begin
      if (!vy[CW-1]) begin
        vx  <= vx + dx;
        vy  <= vy - dy;
        acc <= acc + ang;
      end else begin
        vx  <= vx - dx;
        vy  <= vy + dy;
        acc <= acc - ang;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/dsat_back.sv =====
// Back end: tracker state, reaction delay, slew-limited yaw step, alignment
// check and the result register. Depends on dsat_pkg and dsat_cordic.
`default_nettype none

module dsat_back import dsat_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire cfg_t    cfg,
  input  wire logic    q_avail,
  input  wire q_item_t q_head,
  output logic         q_pop,
  output logic         result_valid,
  input  wire logic    result_ready,
  output logic [15:0]  yaw,
  output logic [2:0]   phase,
  output logic         fire,
  output logic         aligned,
  output logic         tracking,
  output logic [31:0]  fire_tick,
  output logic [31:0]  sighting_count,
  output logic [31:0]  idle_check_count
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_CORDIC = 5'b00010,
    S_APPLY  = 5'b00100,
    S_CHECK  = 5'b01000,
    S_EMIT   = 5'b10000
  } state_t;

  state_t                state;
  logic                  registered;
  logic [31:0]           detect_tick;
  logic [15:0]           yaw_reg;
  logic [31:0]           last_fire;
  logic [COUNT_BITS-1:0] idle_checks;
  logic [COUNT_BITS-1:0] sightings;
  logic                  aligned_flag;
  logic [2:0]            phase_reg;
  logic                  fire_flag;
  logic [15:0]           target;
  logic [31:0]           cur_tick;

  cordic_req_t           creq;
  cordic_rsp_t           crsp;

  logic [31:0]           elapsed;
  logic                  due;
  logic signed [16:0]    diff;
  logic signed [16:0]    lim;
  logic [15:0]           slew;
  logic signed [16:0]    err;
  logic [16:0]           err_abs;
  logic                  out_free;

  dsat_cordic u_cordic (
    .clk (clk),
    .rst (rst),
    .req (creq),
    .rsp (crsp)
  );

  assign elapsed  = q_head.tick - detect_tick;
  assign due      = registered && (elapsed >= {24'd0, cfg.reaction_delay});
  assign q_pop    = (state == S_IDLE) && q_avail;
  assign out_free = !result_valid || result_ready;

  always_comb begin
    creq.start = q_pop && !(!registered && q_head.present) && due && q_head.needs_cordic;
    creq.nx    = q_head.nx;
    creq.ny    = q_head.ny;
    creq.acc   = q_head.acc;
  end

  // shortest-way error; a half turn reads as minus a half turn
  assign diff = 17'(signed'(target - yaw_reg));
  assign lim  = signed'({2'b00, cfg.max_yaw_step});

  always_comb begin
    if (diff > lim) begin
      slew = lim[15:0];
    end else if (diff < -lim) begin
      slew = 16'(-lim);
    end else begin
      slew = diff[15:0];
    end
  end

  assign err     = diff;
  assign err_abs = err[16] ? 17'(-err) : 17'(err);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      registered   <= 1'b0;
      detect_tick  <= '0;
      yaw_reg      <= HOME_YAW_RST;
      last_fire    <= '0;
      idle_checks  <= '0;
      sightings    <= '0;
      aligned_flag <= 1'b0;
      phase_reg    <= PH_IDLE;
      fire_flag    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if ((state == S_EMIT) && out_free) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_avail) begin
            fire_flag <= 1'b0;
            cur_tick  <= q_head.tick;
            if (!registered && q_head.present) begin
              registered  <= 1'b1;
              detect_tick <= q_head.tick;
              phase_reg   <= PH_DELAY;
              sightings   <= sightings + COUNT_BITS'(1);
              state       <= S_EMIT;
            end else if (due) begin
              target <= q_head.fixed_angle;
              state  <= q_head.needs_cordic ? S_CORDIC : S_APPLY;
            end else if (!registered) begin
              phase_reg   <= PH_CHECK;
              idle_checks <= idle_checks + COUNT_BITS'(1);
              state       <= S_EMIT;
            end else begin
              state <= S_EMIT;
            end
          end
        end
        S_CORDIC: begin
          if (crsp.done) begin
            target <= crsp.angle;
            state  <= S_APPLY;
          end
        end
        S_APPLY: begin
          yaw_reg   <= yaw_reg + slew;
          phase_reg <= PH_TURN;
          state     <= S_CHECK;
        end
        S_CHECK: begin
          if (err_abs <= {2'b00, cfg.align_tolerance}) begin
            aligned_flag <= 1'b1;
            phase_reg    <= PH_FIRE;
            fire_flag    <= 1'b1;
            last_fire    <= cur_tick;
            registered   <= 1'b0;
          end else begin
            aligned_flag <= 1'b0;
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_EMIT) && out_free) begin
      yaw              <= yaw_reg;
      phase            <= phase_reg;
      fire             <= fire_flag;
      aligned          <= aligned_flag;
      tracking         <= registered;
      fire_tick        <= last_fire;
      sighting_count   <= 32'(sightings);
      idle_check_count <= 32'(idle_checks);
    end
  end

  a_state_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state))
    else $error("back sequencer state not one-hot");

  a_start_from_idle: assert property (@(posedge clk) disable iff (rst)
    creq.start |=> (state == S_CORDIC) && crsp.busy)
    else $error("CORDIC started outside a turning beat");

  a_done_expected: assert property (@(posedge clk) disable iff (rst)
    crsp.done |-> (state == S_CORDIC))
    else $error("CORDIC result arrived with no beat waiting");

  a_fire_rearms: assert property (@(posedge clk) disable iff (rst)
    ((state == S_EMIT) && fire_flag) |-> (!registered && aligned_flag))
    else $error("fire issued without rearm or alignment");

  a_emit_holds: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> result_valid)
    else $error("result dropped while stalled");

endmodule

`default_nettype wire

// ===== hdl/delayed_slew_limited_aim_tracker.sv =====
// Top level of the aim tracker: APB register file, front end, beat queue
// and back end. Depends on dsat_pkg, dsat_front, dsat_queue and dsat_back.
`default_nettype none

// One tick beat in gives one result beat out. The front end pre-rotates the
// target vector and queues the beat (two entries), so a new beat is taken
// while the back end works or a result waits. A beat that only registers a
// target, counts an idle tick or waits out the reaction delay goes straight
// to the result register in the back end. A turning beat with a target off
// the x axis runs the CORDIC unit, one micro-rotation per cycle, at most 16,
// followed by the slew step, the alignment check and the result register.
// A turning beat with a lost target or one on the x axis skips the CORDIC.
// Registers are to be written only while the block is idle; the block itself
// does not enforce this. A write to home_yaw is only stored, and reset
// returns both it and the yaw to 0.
module delayed_slew_limited_aim_tracker import dsat_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [PADDR_BITS-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  wire logic                  item_valid,
  output logic                       item_ready,
  input  wire logic                  target_present,
  input  wire logic signed [31:0]    target_x,
  input  wire logic signed [31:0]    target_y,
  input  wire logic [31:0]           tick_stamp,
  output logic                       result_valid,
  input  wire logic                  result_ready,
  output logic [15:0]                yaw,
  output logic [2:0]                 phase,
  output logic                       fire,
  output logic                       aligned,
  output logic                       tracking,
  output logic [31:0]                fire_tick,
  output logic [31:0]                sighting_count,
  output logic [31:0]                idle_check_count
);

  cfg_t        cfg;
  logic [15:0] home_yaw;
  reg_idx_t    reg_sel;
  logic        wr_en;

  logic        q_space;
  logic        q_push;
  q_item_t     q_wdata;
  logic        q_pop;
  logic        q_avail;
  q_item_t     q_head;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reaction_delay  <= REACTION_DELAY_RST;
      cfg.max_yaw_step    <= MAX_YAW_STEP_RST;
      cfg.align_tolerance <= ALIGN_TOL_RST;
      home_yaw            <= HOME_YAW_RST;
    end else if (wr_en) begin
      case (reg_sel)
        REG_REACTION_DELAY: cfg.reaction_delay  <= pwdata[7:0];
        REG_MAX_YAW_STEP:   cfg.max_yaw_step    <= pwdata[14:0];
        REG_ALIGN_TOL:      cfg.align_tolerance <= pwdata[14:0];
        REG_HOME_YAW:       home_yaw            <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_REACTION_DELAY: prdata = {24'd0, cfg.reaction_delay};
      REG_MAX_YAW_STEP:   prdata = {17'd0, cfg.max_yaw_step};
      REG_ALIGN_TOL:      prdata = {17'd0, cfg.align_tolerance};
      REG_HOME_YAW:       prdata = {16'd0, home_yaw};
      default:            prdata = '0;
    endcase
  end

  dsat_front u_front (
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .target_present (target_present),
    .target_x       (target_x),
    .target_y       (target_y),
    .tick_stamp     (tick_stamp),
    .q_space        (q_space),
    .q_push         (q_push),
    .q_wdata        (q_wdata)
  );

  dsat_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .space (q_space),
    .pop   (q_pop),
    .avail (q_avail),
    .head  (q_head)
  );

  dsat_back u_back (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .q_avail          (q_avail),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .result_valid     (result_valid),
    .result_ready     (result_ready),
    .yaw              (yaw),
    .phase            (phase),
    .fire             (fire),
    .aligned          (aligned),
    .tracking         (tracking),
    .fire_tick        (fire_tick),
    .sighting_count   (sighting_count),
    .idle_check_count (idle_check_count)
  );

endmodule

`default_nettype wire

// ===== tb/sv/delayed_slew_limited_aim_tracker_test.sv =====
`timescale 1ns / 100ps
// Self-checking test of the delayed slew-limited aim tracker: APB register setup,
// directed and random tick beats, and a cycle-free predictor of every result beat.
// Depends on dsat_pkg and delayed_slew_limited_aim_tracker.

module delayed_slew_limited_aim_tracker_test;
  import dsat_pkg::*;

  typedef struct {
    logic        present;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] tick;
  } tick_beat_t;

  typedef struct {
    logic [15:0] yaw;
    logic [2:0]  phase;
    logic        fire;
    logic        aligned;
    logic        tracking;
    logic [31:0] fire_tick;
    logic [31:0] sightings;
    logic [31:0] idle_checks;
  } aim_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [PADDR_BITS-1:0] paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;
  logic                  item_valid = 1'b0;
  logic                  item_ready;
  logic                  target_present = 1'b0;
  logic signed [31:0]    target_x = '0;
  logic signed [31:0]    target_y = '0;
  logic [31:0]           tick_stamp = '0;
  logic                  result_valid;
  logic                  result_ready = 1'b0;
  logic [15:0]           yaw;
  logic [2:0]            phase;
  logic                  fire;
  logic                  aligned;
  logic                  tracking;
  logic [31:0]           fire_tick;
  logic [31:0]           sighting_count;
  logic [31:0]           idle_check_count;

  delayed_slew_limited_aim_tracker i_dut (.*);

  always #6 clk = ~clk;

  // predictor copy of the registers
  logic [7:0]  cfg_delay    = REACTION_DELAY_RST;
  logic [14:0] cfg_step     = MAX_YAW_STEP_RST;
  logic [14:0] cfg_tol      = ALIGN_TOL_RST;
  logic [15:0] cfg_init_yaw = HOME_YAW_RST;

  // predictor copy of the tracker state
  logic        trk_registered  = 1'b0;
  logic [31:0] trk_detect_tick = '0;
  logic [15:0] trk_yaw         = HOME_YAW_RST;
  logic [31:0] trk_last_fire   = '0;
  logic [31:0] trk_idle_checks = '0;
  logic [31:0] trk_sightings   = '0;
  logic        trk_aligned     = 1'b0;
  logic [2:0]  trk_phase       = PH_IDLE;

  aim_result_t expected_aims[$];
  aim_result_t want;
  logic [31:0] tick_now = '0;
  logic        calm = 1'b0;
  int          errors = 0;
  int          beats_sent = 0;
  int          fires_seen = 0;
  int          settings_used = 0;

  // binary angle of (x, y), vectoring CORDIC after a quarter-turn pre-rotation
  function automatic logic [15:0] bearing_of(input longint x, input longint y);
    longint      nx, ny, dx, dy;
    logic [31:0] acc;
    if (y == 0) return (x < 0) ? HALF_TURN : 16'd0;
    if (y > 0) begin
      nx = y;  ny = -x; acc = ACC_QUARTER;
    end else begin
      nx = -y; ny = x;  acc = ACC_3QUARTER;
    end
    for (int i = 0; i < RUN_STEPS; i++) begin
      if (ny == 0) break;
      dx = ny >>> i;
      dy = nx >>> i;
      if (ny > 0) begin
        nx = nx + dx; ny = ny - dy; acc = acc + ATAN_TABLE[i];
      end else begin
        nx = nx - dx; ny = ny + dy; acc = acc - ATAN_TABLE[i];
      end
    end
    return acc[31:16];
  endfunction

  // shortest-way error; a half turn counts as negative
  function automatic int yaw_error(input logic [15:0] aim, input logic [15:0] cur);
    logic [15:0] d;
    d = aim - cur;
    return (d >= 16'd32768) ? int'(d) - 65536 : int'(d);
  endfunction

  task automatic advance_tracker(input tick_beat_t b, output aim_result_t r);
    logic [15:0] aim;
    logic [31:0] waited;
    logic        fired;
    int          d, lim, err;
    fired  = 1'b0;
    waited = b.tick - trk_detect_tick;
    if (!trk_registered && b.present) begin
      trk_registered  = 1'b1;
      trk_detect_tick = b.tick;
      trk_phase       = PH_DELAY;
      trk_sightings   = trk_sightings + 1;
    end else if (trk_registered && waited >= {24'd0, cfg_delay}) begin
      // a lost target pulls the aim back to angle zero
      aim = b.present ? bearing_of(longint'($signed(b.x)), longint'($signed(b.y))) : 16'd0;
      d   = yaw_error(aim, trk_yaw);
      lim = int'(cfg_step);
      if (d > lim) d = lim;
      else if (d < -lim) d = -lim;
      trk_yaw   = trk_yaw + d[15:0];
      trk_phase = PH_TURN;
      err = yaw_error(aim, trk_yaw);
      if (err < 0) err = -err;
      if (err <= int'(cfg_tol)) begin
        trk_aligned    = 1'b1;
        trk_phase      = PH_FIRE;
        fired          = 1'b1;
        trk_last_fire  = b.tick;
        trk_registered = 1'b0;
      end else begin
        trk_aligned = 1'b0;
      end
    end else if (!trk_registered) begin
      trk_phase       = PH_CHECK;
      trk_idle_checks = trk_idle_checks + 1;
    end
    r = '{trk_yaw, trk_phase, fired, trk_aligned, trk_registered,
          trk_last_fire, trk_sightings, trk_idle_checks};
  endtask

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      errors++;
      $error("%s: expected %0h, got %0h", name, want_v, got_v);
    end
  endtask

  function automatic logic [PADDR_BITS-1:0] reg_addr(input reg_idx_t idx);
    return PADDR_BITS'({idx, 2'b00});
  endfunction

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= reg_addr(idx);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_REACTION_DELAY: cfg_delay    = value[7:0];
      REG_MAX_YAW_STEP:   cfg_step     = value[14:0];
      REG_ALIGN_TOL:      cfg_tol      = value[14:0];
      REG_HOME_YAW:       cfg_init_yaw = value[15:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic read_reg(input reg_idx_t idx);
    logic [31:0] want_v;
    case (idx)
      REG_REACTION_DELAY: want_v = {24'd0, cfg_delay};
      REG_MAX_YAW_STEP:   want_v = {17'd0, cfg_step};
      REG_ALIGN_TOL:      want_v = {17'd0, cfg_tol};
      default:            want_v = {16'd0, cfg_init_yaw};
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= reg_addr(idx);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    // prdata is valid during the access cycle
    check_field($sformatf("prdata[%s]", idx.name()), want_v, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Call at a clock edge. Valid stays up across back-to-back beats.
  task automatic send_beat(input logic present, input logic [31:0] x, y, tick);
    tick_beat_t  b;
    aim_result_t r;
    b = '{present, x, y, tick};
    if (!calm) begin
      while ($urandom_range(99) < 32) begin
        item_valid <= 1'b0;
        @(posedge clk);
      end
    end
    item_valid     <= 1'b1;
    target_present <= present;
    target_x       <= x;
    target_y       <= y;
    tick_stamp     <= tick;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    advance_tracker(b, r);
    expected_aims.push_back(r);
    beats_sent++;
  endtask

  // hold off input until every result is back, then let the pipe go quiet
  task automatic settle_block();
    item_valid <= 1'b0;
    @(posedge clk);
    while (expected_aims.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic apply_setting(input logic [7:0] delay, input logic [14:0] step,
                               input logic [14:0] tol, input logic [15:0] init_yaw);
    settle_block();
    // junk in the unused upper bits must be dropped
    write_reg(REG_REACTION_DELAY, ($urandom & 32'hFFFF_FF00) | {24'd0, delay});
    write_reg(REG_MAX_YAW_STEP,   ($urandom & 32'hFFFF_8000) | {17'd0, step});
    write_reg(REG_ALIGN_TOL,      ($urandom & 32'hFFFF_8000) | {17'd0, tol});
    write_reg(REG_HOME_YAW,       ($urandom & 32'hFFFF_0000) | {16'd0, init_yaw});
    read_reg(REG_REACTION_DELAY);
    read_reg(REG_MAX_YAW_STEP);
    read_reg(REG_ALIGN_TOL);
    read_reg(REG_HOME_YAW);
    settings_used++;
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'd0;
      3, 4:    return 32'($urandom_range(2000)) - 32'd1000;
      5:       return 32'($urandom_range(1 << 20)) - 32'd524288;
      default: return $urandom;
    endcase
  endfunction

  // mostly steady targets held for a while, with dropouts and raw noise
  task automatic run_engagements(input int count);
    int          stop, len;
    logic [31:0] ex, ey;
    stop = beats_sent + count;
    while (beats_sent < stop) begin
      if ($urandom_range(99) < 75) begin
        ex  = pick_coord();
        ey  = pick_coord();
        len = $urandom_range(1, 24);
        repeat (len) begin
          if ($urandom_range(99) < 20) begin
            ex = ex + 32'($urandom_range(64)) - 32'd32;
            ey = ey + 32'($urandom_range(64)) - 32'd32;
          end
          tick_now = tick_now + $urandom_range(1, 1 + cfg_delay / 4);
          send_beat($urandom_range(99) >= 5, ex, ey, tick_now);
        end
        repeat ($urandom_range(3)) begin
          tick_now = tick_now + 1;
          send_beat(1'b0, $urandom, $urandom, tick_now);
        end
      end else begin
        if ($urandom_range(3) == 0) tick_now = $urandom;
        else tick_now = tick_now + $urandom_range(300);
        send_beat(1'($urandom_range(1)), $urandom, $urandom, tick_now);
      end
    end
  endtask

  task automatic test_register_defaults();
    read_reg(REG_REACTION_DELAY);
    read_reg(REG_MAX_YAW_STEP);
    read_reg(REG_ALIGN_TOL);
    read_reg(REG_HOME_YAW);
  endtask

  // default setting: idle tick, detection just before the tick counter wraps,
  // delay not yet passed, then a half-turn aim and a lost target
  task automatic test_reaction_delay_wrap();
    send_beat(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
    send_beat(1'b1, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFF8);
    send_beat(1'b1, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
    send_beat(1'b0, 32'd0, 32'd0, 32'h0000_0006);
    send_beat(1'b1, 32'hFFFF_FFFF, 32'd0, 32'h0000_0007);
    send_beat(1'b0, 32'd0, 32'd0, 32'h0000_0008);
    tick_now = 32'h0000_0008;
  endtask

  task automatic test_axis_angles();
    logic [31:0] pts [9][2];
    pts = '{'{32'd5, 32'd0}, '{32'hFFFF_FFFB, 32'd0}, '{32'd0, 32'd0},
            '{32'd0, 32'h7FFF_FFFF}, '{32'd0, 32'h8000_0000},
            '{32'h7FFF_FFFF, 32'h7FFF_FFFF}, '{32'h8000_0000, 32'h8000_0000},
            '{32'h8000_0000, 32'h7FFF_FFFF}, '{32'h8000_0000, 32'hFFFF_FFFF}};
    apply_setting(8'd0, 15'h7FFF, 15'd0, 16'hFFFF);
    foreach (pts[i]) begin
      tick_now = tick_now + 1;
      send_beat(1'b1, pts[i][0], pts[i][1], tick_now);
      tick_now = tick_now + 1;
      send_beat(1'b1, pts[i][0], pts[i][1], tick_now);
    end
    tick_now = tick_now + 1;
    send_beat(1'b1, 32'd100, 32'd100, tick_now);
    tick_now = tick_now + 1;
    send_beat(1'b0, 32'd100, 32'd100, tick_now);
  endtask

  task automatic test_random_engagements();
    apply_setting(8'd0, 15'h7FFF, 15'h7FFF, 16'h0000);
    run_engagements(40);
    apply_setting(8'd255, 15'd0, 15'd0, 16'h0000);
    run_engagements(30);
    apply_setting(8'd1, 15'h7FFF, 15'd0, 16'($urandom));
    run_engagements(40);
    // long stretch with no idling on either side
    calm = 1'b1;
    apply_setting(REACTION_DELAY_RST, MAX_YAW_STEP_RST, ALIGN_TOL_RST, 16'($urandom));
    run_engagements(60);
    calm = 1'b0;
    repeat (4) begin
      apply_setting(8'($urandom), 15'($urandom_range(16, 6000)),
                    15'($urandom_range(0, 3000)), 16'($urandom));
      run_engagements(35);
    end
    apply_setting(8'($urandom), 15'($urandom), 15'($urandom), 16'($urandom));
    run_engagements(15);
  endtask

  always @(posedge clk) begin
    if (calm) result_ready <= 1'b1;
    else result_ready <= ($urandom_range(99) >= 32);
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (expected_aims.size() == 0) begin
        errors++;
        $error("result beat with no expectation waiting");
      end else begin
        want = expected_aims.pop_front();
        check_field("yaw", 32'(want.yaw), 32'(yaw));
        check_field("phase", 32'(want.phase), 32'(phase));
        check_field("fire", 32'(want.fire), 32'(fire));
        check_field("aligned", 32'(want.aligned), 32'(aligned));
        check_field("tracking", 32'(want.tracking), 32'(tracking));
        check_field("fire_tick", want.fire_tick, fire_tick);
        check_field("sighting_count", want.sightings, sighting_count);
        check_field("idle_check_count", want.idle_checks, idle_check_count);
        if (want.fire) fires_seen++;
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_register_defaults();
    test_reaction_delay_wrap();
    test_axis_angles();
    test_random_engagements();
    settle_block();
    $display("Checked %0d tick beats over %0d register settings, %0d of them firing.",
             beats_sent, settings_used, fires_seen);
    $display("Covered delay wrap, axis and extreme vectors, lost targets, random tracks.");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
